// ----- hdl/eht_pkg.sv -----
// ----------------------------------------------------------------------------
// Entropy health test package
// Shared types, status codes, register indexes and reset values for the
// repetition count and adaptive proportion health tests.
// ----------------------------------------------------------------------------
package eht_pkg;

  // Field widths
  localparam int unsigned CutoffW  = 16;
  localparam int unsigned StartupW = 20;
  localparam int unsigned SampleW  = 32;
  localparam int unsigned StatW    = 16;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 20;

  // Default counter width
  localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

  // Health status codes
  localparam logic [1:0] ST_WARMING  = 2'd0;
  localparam logic [1:0] ST_OK       = 2'd1;
  localparam logic [1:0] ST_FAIL_RCT = 2'd2;
  localparam logic [1:0] ST_FAIL_APT = 2'd3;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CFG_RUN_CUTOFF        = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_WINDOW_SIZE       = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_PROPORTION_CUTOFF = 2'd2;
  localparam logic [CfgAddrW-1:0] CFG_STARTUP_LENGTH    = 2'd3;

  // Configuration reset values
  localparam logic [CutoffW-1:0]  RUN_CUTOFF_RST        = 16'd21;
  localparam logic [CutoffW-1:0]  WINDOW_SIZE_RST       = 16'd1024;
  localparam logic [CutoffW-1:0]  PROPORTION_CUTOFF_RST = 16'd589;
  localparam logic [StartupW-1:0] STARTUP_LENGTH_RST    = 20'd1024;

  // Configuration register set
  typedef struct packed {
    logic [CutoffW-1:0]  run_cutoff;
    logic [CutoffW-1:0]  window_size;
    logic [CutoffW-1:0]  proportion_cutoff;
    logic [StartupW-1:0] startup_length;
  } cfg_t;

  // Result of one request
  typedef struct packed {
    logic [1:0]         health_status;
    logic               passing;
    logic [SampleW-1:0] bits_accepted;
    logic [StatW-1:0]   longest_run_seen;
    logic [StatW-1:0]   highest_window_count;
  } result_t;

endpackage

// ----- hdl/eht_tests.sv -----
// ----------------------------------------------------------------------------
// Entropy health test core
// Holds the test state and updates it for one request per step: repetition
// count test, adaptive proportion test, failure latch and startup tracking.
// ----------------------------------------------------------------------------
module eht_tests #(
  parameter int unsigned COUNT_WIDTH = eht_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             restart_i,
  input  logic             bit_i,
  input  eht_pkg::cfg_t    cfg_i,
  output eht_pkg::result_t res_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > eht_pkg::CutoffW) ?
                                 COUNT_WIDTH : eht_pkg::CutoffW;
  localparam int unsigned PosW = eht_pkg::CutoffW;
  localparam int unsigned SmpW = eht_pkg::SampleW;

  logic [1:0]             status_q, status_d;
  logic [SmpW-1:0]        sample_count_q, sample_count_d;
  logic                   last_valid_q, last_valid_d;
  logic                   last_bit_q, last_bit_d;
  logic [COUNT_WIDTH-1:0] run_q, run_d;
  logic [COUNT_WIDTH-1:0] max_run_q, max_run_d;
  logic                   ref_bit_q, ref_bit_d;
  logic [COUNT_WIDTH-1:0] ref_count_q, ref_count_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic [COUNT_WIDTH-1:0] max_win_q, max_win_d;

  // Compute the state after the current request
  always_comb begin
    logic                   fresh;
    logic                   failed;
    logic                   open_win;
    logic                   apt_fail;
    logic [COUNT_WIDTH-1:0] run_n;
    logic [COUNT_WIDTH-1:0] cnt_n;
    logic [SmpW-1:0]        sc_n;

    status_d       = status_q;
    sample_count_d = sample_count_q;
    last_valid_d   = last_valid_q;
    last_bit_d     = last_bit_q;
    run_d          = run_q;
    max_run_d      = max_run_q;
    ref_bit_d      = ref_bit_q;
    ref_count_d    = ref_count_q;
    pos_d          = pos_q;
    max_win_d      = max_win_q;

    fresh    = !last_valid_q;
    failed   = (status_q == eht_pkg::ST_FAIL_RCT) || (status_q == eht_pkg::ST_FAIL_APT);
    open_win = fresh || (pos_q >= cfg_i.window_size);
    apt_fail = 1'b0;
    cnt_n    = ref_count_q;
    sc_n     = sample_count_q;

    // Extend or restart the current run
    if (!fresh && (bit_i == last_bit_q)) begin
      run_n = (run_q == '1) ? run_q : run_q + COUNT_WIDTH'(1);
    end else begin
      run_n = COUNT_WIDTH'(1);
    end

    if (step_i) begin
      if (restart_i) begin
        // Return all test state to its reset value, with the window position set to the configured window size
        status_d       = eht_pkg::ST_WARMING;
        sample_count_d = '0;
        last_valid_d   = 1'b0;
        last_bit_d     = 1'b0;
        run_d          = '0;
        max_run_d      = '0;
        ref_bit_d      = 1'b0;
        ref_count_d    = '0;
        pos_d          = cfg_i.window_size;
        max_win_d      = '0;
      end else if (!failed) begin
        last_bit_d   = bit_i;
        last_valid_d = 1'b1;
        run_d        = run_n;
        if (run_n > max_run_q) begin
          max_run_d = run_n;
        end

        if (CmpW'(run_n) >= CmpW'(cfg_i.run_cutoff)) begin
          status_d = eht_pkg::ST_FAIL_RCT;
        end else begin
          // Open a new window or count into the current one
          if (open_win) begin
            if (ref_count_q > max_win_q) begin
              max_win_d = ref_count_q;
            end
            ref_bit_d   = bit_i;
            ref_count_d = COUNT_WIDTH'(1);
            pos_d       = PosW'(1);
          end else begin
            if (bit_i == ref_bit_q) begin
              cnt_n = (ref_count_q == '1) ? ref_count_q : ref_count_q + COUNT_WIDTH'(1);
            end
            ref_count_d = cnt_n;
            pos_d       = (pos_q == '1) ? pos_q : pos_q + PosW'(1);
            apt_fail    = CmpW'(cnt_n) >= CmpW'(cfg_i.proportion_cutoff);
          end

          if (apt_fail) begin
            status_d = eht_pkg::ST_FAIL_APT;
          end else begin
            // Count the accepted bit and leave warming when due
            sc_n = (sample_count_q == '1) ? sample_count_q : sample_count_q + SmpW'(1);
            sample_count_d = sc_n;
            if ((status_q == eht_pkg::ST_WARMING) && (sc_n >= SmpW'(cfg_i.startup_length))) begin
              status_d = eht_pkg::ST_OK;
            end
          end
        end
      end
    end
  end

  // Hold the test state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q       <= eht_pkg::ST_WARMING;
      sample_count_q <= '0;
      last_valid_q   <= 1'b0;
      last_bit_q     <= 1'b0;
      run_q          <= '0;
      max_run_q      <= '0;
      ref_bit_q      <= 1'b0;
      ref_count_q    <= '0;
      pos_q          <= eht_pkg::WINDOW_SIZE_RST;
      max_win_q      <= '0;
    end else begin
      status_q       <= status_d;
      sample_count_q <= sample_count_d;
      last_valid_q   <= last_valid_d;
      last_bit_q     <= last_bit_d;
      run_q          <= run_d;
      max_run_q      <= max_run_d;
      ref_bit_q      <= ref_bit_d;
      ref_count_q    <= ref_count_d;
      pos_q          <= pos_d;
      max_win_q      <= max_win_d;
    end
  end

  // Report the state after the request
  always_comb begin
    res_o.health_status        = status_d;
    res_o.passing              = (status_d == eht_pkg::ST_OK);
    res_o.bits_accepted        = sample_count_d;
    res_o.longest_run_seen     = eht_pkg::StatW'(max_run_d);
    res_o.highest_window_count = eht_pkg::StatW'(max_win_d);
  end

endmodule

// ----- hdl/entropy_health_test_rct_apt.sv -----
// ----------------------------------------------------------------------------
// Entropy health test, repetition count and adaptive proportion
// Continuous health tests on a raw binary noise stream with latched failure.
// ----------------------------------------------------------------------------
// Each request carries one noise bit or a restart, and produces exactly one
// result showing the health status and statistics after that request. The
// block takes one request per cycle while the result channel does not stall:
// a request register feeds the combinational test update, whose outcome lands
// in the result register. Back-to-back requests run at full rate, as the
// test state loop closes within the update. The result register lets a new
// request enter while a finished result still waits. The user must write
// configuration registers through the plain write port only while no
// request is in flight; the block does not enforce this. COUNT_WIDTH sets
// the width of the run and window counters, which saturate.
module entropy_health_test_rct_apt #(
  parameter int unsigned COUNT_WIDTH = eht_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [eht_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [eht_pkg::CfgDataW-1:0]       cfg_wdata_i,
  // Request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic                               sample_bit_i,
  // Result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         health_status_o,
  output logic                               passing_o,
  output logic [eht_pkg::SampleW-1:0]        bits_accepted_o,
  output logic [eht_pkg::StatW-1:0]          longest_run_seen_o,
  output logic [eht_pkg::StatW-1:0]          highest_window_count_o
);

  eht_pkg::cfg_t    cfg_q;
  logic             in_valid_q;
  logic             req_q;
  logic             bit_q;
  logic             out_valid_q;
  logic             out_ready;
  logic             advance;
  eht_pkg::result_t res_d;
  eht_pkg::result_t res_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_cutoff        <= eht_pkg::RUN_CUTOFF_RST;
      cfg_q.window_size       <= eht_pkg::WINDOW_SIZE_RST;
      cfg_q.proportion_cutoff <= eht_pkg::PROPORTION_CUTOFF_RST;
      cfg_q.startup_length    <= eht_pkg::STARTUP_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        eht_pkg::CFG_RUN_CUTOFF: begin
          cfg_q.run_cutoff <= cfg_wdata_i[eht_pkg::CutoffW-1:0];
        end
        eht_pkg::CFG_WINDOW_SIZE: begin
          cfg_q.window_size <= cfg_wdata_i[eht_pkg::CutoffW-1:0];
        end
        eht_pkg::CFG_PROPORTION_CUTOFF: begin
          cfg_q.proportion_cutoff <= cfg_wdata_i[eht_pkg::CutoffW-1:0];
        end
        eht_pkg::CFG_STARTUP_LENGTH: begin
          cfg_q.startup_length <= cfg_wdata_i[eht_pkg::StartupW-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Advance when the result register is free or being drained
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  // Hold the request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      req_q <= req_type_i;
      bit_q <= sample_bit_i;
    end
  end

  // Run the tests on the registered request
  eht_tests #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tests (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .restart_i (req_q),
    .bit_i     (bit_q),
    .cfg_i     (cfg_q),
    .res_o     (res_d)
  );

  // Hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        res_q <= res_d;
      end
    end
  end

  assign out_valid_o            = out_valid_q;
  assign health_status_o        = res_q.health_status;
  assign passing_o              = res_q.passing;
  assign bits_accepted_o        = res_q.bits_accepted;
  assign longest_run_seen_o     = res_q.longest_run_seen;
  assign highest_window_count_o = res_q.highest_window_count;

  // A latched failure ignores noise bits
  a_fail_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !req_q && ((res_q.health_status == eht_pkg::ST_FAIL_RCT) ||
                           (res_q.health_status == eht_pkg::ST_FAIL_APT)))
    |=> (res_q == $past(res_q)))
    else $error("noise bit changed state after a latched failure");

  // Accepted bit count never falls without a restart
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !req_q) |=> (res_q.bits_accepted >= $past(res_q.bits_accepted)))
    else $error("accepted bit count decreased without restart");

  // A restart always reports warming with cleared statistics
  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && req_q) |=> ((res_q.health_status == eht_pkg::ST_WARMING) &&
                            (res_q.bits_accepted == '0) &&
                            (res_q.longest_run_seen == '0)))
    else $error("restart did not clear the test state");

  // An empty result register never stalls requests
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled with empty result register");

endmodule
